// ===== src/assert_macros.svh =====
// Assertion macros used by the top level of the frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The property must hold at every clock edge outside reset.
`define FRP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("frame parser assertion failed");

// The condition must never be true outside reset.
`define FRP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("frame parser forbidden condition seen");

`else

`define FRP_ASSERT(lbl, clk, rst_n, prop)
`define FRP_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== src/frp_pkg.sv =====
// Types and constants of the framed response parser.
package frp_pkg;

    localparam logic [7:0] HDR_FIRST        = 8'hAA;
    localparam logic [7:0] HDR_SECOND       = 8'h55;
    localparam logic [7:0] TAIL_BYTE        = 8'h66;
    localparam logic [7:0] DEV_ERR_UNKNOWN  = 8'hEE;
    localparam logic [7:0] DEV_ERR_CHECKSUM = 8'hEC;
    localparam logic [6:0] HUNT_LIMIT       = 7'd64;
    localparam logic [7:0] LENGTH_LIMIT_RST = 8'd32;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_CSUM = 3'd4,
        PH_TAIL = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_BAD      = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_CHECKSUM = 3'd4
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] frame_len;
        logic [7:0] frame_command;
        logic [7:0] data_byte;
        logic       kind;
    } frp_result_t;

endpackage

// ===== src/frp_core.sv =====
// Frame parser state machine: one input item per step, at most one result.
module frp_core
    import frp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        step,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    output frp_result_t res
);

    phase_t     phase_reg, phase_next;
    logic       seen_reg, seen_next;
    logic [6:0] hunt_count_reg, hunt_count_next;
    logic [7:0] held_command_reg, held_command_next;
    logic [7:0] held_length_reg, held_length_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] checksum_reg, checksum_next;
    logic [7:0] length_limit_reg;
    logic [6:0] hunt_inc;
    logic       clear;

    assign hunt_inc = hunt_count_reg + 7'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_limit_reg <= LENGTH_LIMIT_RST;
        end else if (cfg_we) begin
            length_limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT;
            seen_reg         <= 1'b0;
            hunt_count_reg   <= '0;
            held_command_reg <= '0;
            held_length_reg  <= '0;
            bytes_left_reg   <= '0;
            sum_reg          <= '0;
            checksum_reg     <= '0;
        end else begin
            phase_reg        <= phase_next;
            seen_reg         <= seen_next;
            hunt_count_reg   <= hunt_count_next;
            held_command_reg <= held_command_next;
            held_length_reg  <= held_length_next;
            bytes_left_reg   <= bytes_left_next;
            sum_reg          <= sum_next;
            checksum_reg     <= checksum_next;
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        seen_next         = seen_reg;
        hunt_count_next   = hunt_count_reg;
        held_command_next = held_command_reg;
        held_length_next  = held_length_reg;
        bytes_left_next   = bytes_left_reg;
        sum_next          = sum_reg;
        checksum_next     = checksum_reg;
        clear             = 1'b0;
        res_valid         = 1'b0;
        res.kind          = KIND_PAYLOAD;
        res.data_byte     = '0;
        res.frame_command = held_command_reg;
        res.frame_len     = held_length_reg;
        res.status        = ST_OK;

        if (step) begin
            if (op == OP_TIMEOUT) begin
                res_valid  = 1'b1;
                res.kind   = KIND_STATUS;
                res.status = ST_TIMEOUT;
                clear      = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_HUNT: begin
                        hunt_count_next = hunt_inc;
                        if (seen_reg && rx_byte == HDR_SECOND) begin
                            seen_next       = 1'b0;
                            hunt_count_next = '0;
                            phase_next      = PH_CMD;
                        end else begin
                            seen_next = (rx_byte == HDR_FIRST);
                            if (hunt_inc >= HUNT_LIMIT) begin
                                res_valid  = 1'b1;
                                res.kind   = KIND_STATUS;
                                res.status = ST_BAD;
                                clear      = 1'b1;
                            end
                        end
                    end
                    PH_CMD: begin
                        held_command_next = rx_byte;
                        phase_next        = PH_LEN;
                    end
                    PH_LEN: begin
                        held_length_next = rx_byte;
                        res.frame_len    = rx_byte;
                        if (rx_byte > length_limit_reg) begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_STATUS;
                            res.status = ST_BAD;
                            clear      = 1'b1;
                        end else begin
                            sum_next        = held_command_reg + rx_byte;
                            bytes_left_next = rx_byte;
                            phase_next      = (rx_byte == 8'd0) ? PH_CSUM : PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        sum_next        = sum_reg + rx_byte;
                        bytes_left_next = bytes_left_reg - 8'd1;
                        if (bytes_left_reg == 8'd1) begin
                            phase_next = PH_CSUM;
                        end
                        res_valid     = 1'b1;
                        res.data_byte = rx_byte;
                    end
                    PH_CSUM: begin
                        checksum_next = rx_byte;
                        phase_next    = PH_TAIL;
                    end
                    PH_TAIL: begin
                        res_valid = 1'b1;
                        res.kind  = KIND_STATUS;
                        clear     = 1'b1;
                        if (rx_byte != TAIL_BYTE) begin
                            res.status = ST_BAD;
                        end else if (held_command_reg == DEV_ERR_UNKNOWN) begin
                            res.status = ST_UNKNOWN;
                        end else if (held_command_reg == DEV_ERR_CHECKSUM) begin
                            res.status = ST_CHECKSUM;
                        end else if (sum_reg != checksum_reg) begin
                            res.status = ST_CHECKSUM;
                        end else begin
                            res.status = ST_OK;
                        end
                    end
                    default: begin
                        clear = 1'b1;
                    end
                endcase
            end

            // Any frame end drops back to header hunt with a clean slate.
            if (clear) begin
                phase_next        = PH_HUNT;
                seen_next         = 1'b0;
                hunt_count_next   = '0;
                held_command_next = '0;
                held_length_next  = '0;
                bytes_left_next   = '0;
                sum_next          = '0;
                checksum_next     = '0;
            end
        end
    end

endmodule

// ===== src/frp_out_stage.sv =====
// Result register that drives the master stream port.
module frp_out_stage
    import frp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  frp_result_t load_data,
    output logic        free,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [31:0] m_tdata,
    output logic [0:0]  m_tuser
);

    logic        valid_reg;
    frp_result_t data_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.kind;
    assign m_tdata  = {5'd0, data_reg.status, data_reg.frame_len,
                       data_reg.frame_command, data_reg.data_byte};

endmodule

// ===== src/framed_response_parser.sv =====
// Top level of the framed response parser: input register, parser core, result register.
//
//  Port group | Direction | Carries
//  s_*        | in        | received byte or timeout event
//  m_*        | out       | passed payload byte or frame end status
//  cfg_*      | in        | payload length limit register
//
// One item is accepted per cycle when the result side keeps up.
// An accepted item is held in the input register and parsed from there once the result
// register is free; any result is then loaded into the result register.
// Reset is synchronous and active low; it returns the parser to header hunt.
// A stalled result holds the input register; s_tready drops once both are full.
`include "assert_macros.svh"

module framed_response_parser
    import frp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] data_byte, [15:8] frame_command,
                                   // [23:16] frame_len, [26:24] status
    output logic [0:0]  m_tuser    // [0] kind
);

    logic        in_valid_reg;
    logic        in_op_reg;
    logic [7:0]  in_byte_reg;
    logic        out_free;
    logic        step;
    logic        res_valid;
    frp_result_t res;

    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
    end

    frp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .op        (in_op_reg),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    frp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .load_data (res),
        .free      (out_free),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    `FRP_ASSERT(a_stall_only_when_full, aclk, aresetn, !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
    `FRP_ASSERT(a_payload_status_ok, aclk, aresetn, (m_tvalid && m_tuser[0] == KIND_PAYLOAD) |-> (m_tdata[26:24] == ST_OK))
    `FRP_ASSERT(a_status_no_data, aclk, aresetn, (m_tvalid && m_tuser[0] == KIND_STATUS) |-> (m_tdata[7:0] == 8'd0))
    `FRP_ASSERT_NEVER(a_result_without_step, aclk, aresetn, res_valid && !step)

endmodule

// ===== dv/tb_framed_response_parser.sv =====
// Self-checking testbench for the framed response parser: frame stimulus, prediction, checks.
module tb_framed_response_parser
    import frp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT      = 300000;
    localparam int HOLD_CYCLES      = 200;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_PER_PHASE = 15;

    typedef enum {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_BAD_TAIL,
        FRAME_CUT,
        FRAME_LONG
    } frame_flaw_t;

    // Tracks the parser state item by item and holds the results it owes.
    class frp_scoreboard;
        phase_t      parse_phase;
        bit          saw_first;
        logic [6:0]  hunt_count;
        logic [7:0]  cur_command;
        logic [7:0]  cur_length;
        logic [7:0]  left_count;
        logic [7:0]  run_sum;
        logic [7:0]  got_checksum;
        logic [7:0]  length_limit;
        frp_result_t expected_results[$];
        int          errors;

        function new();
            length_limit = LENGTH_LIMIT_RST;
            errors = 0;
            restart_hunt();
        endfunction

        function void restart_hunt();
            parse_phase = PH_HUNT;
            saw_first = 1'b0;
            hunt_count = '0;
            cur_command = '0;
            cur_length = '0;
            left_count = '0;
            run_sum = '0;
            got_checksum = '0;
        endfunction

        function void set_limit(logic [7:0] value);
            length_limit = value;
        endfunction

        function void add_result(logic kind, logic [7:0] data, status_t status);
            frp_result_t r;
            r.kind = kind;
            r.data_byte = data;
            r.frame_command = cur_command;
            r.frame_len = cur_length;
            r.status = status;
            expected_results.push_back(r);
        endfunction

        function void end_frame(status_t status);
            add_result(KIND_STATUS, 8'h00, status);
            restart_hunt();
        endfunction

        function void predict_item(logic op, logic [7:0] b);
            if (op == OP_TIMEOUT) begin
                end_frame(ST_TIMEOUT);
                return;
            end
            case (parse_phase)
                PH_HUNT: begin
                    hunt_count = hunt_count + 7'd1;
                    // A completed header wins even on the last byte of the hunt.
                    if (saw_first && b == HDR_SECOND) begin
                        saw_first = 1'b0;
                        hunt_count = '0;
                        parse_phase = PH_CMD;
                    end else begin
                        saw_first = (b == HDR_FIRST);
                        if (hunt_count >= HUNT_LIMIT)
                            end_frame(ST_BAD);
                    end
                end
                PH_CMD: begin
                    cur_command = b;
                    parse_phase = PH_LEN;
                end
                PH_LEN: begin
                    cur_length = b;
                    if (b > length_limit) begin
                        end_frame(ST_BAD);
                    end else begin
                        run_sum = cur_command + b;
                        left_count = b;
                        parse_phase = (b == 8'd0) ? PH_CSUM : PH_DATA;
                    end
                end
                PH_DATA: begin
                    run_sum = run_sum + b;
                    left_count = left_count - 8'd1;
                    if (left_count == 8'd0)
                        parse_phase = PH_CSUM;
                    add_result(KIND_PAYLOAD, b, ST_OK);
                end
                PH_CSUM: begin
                    got_checksum = b;
                    parse_phase = PH_TAIL;
                end
                PH_TAIL: begin
                    if (b != TAIL_BYTE)
                        end_frame(ST_BAD);
                    else if (cur_command == DEV_ERR_UNKNOWN)
                        end_frame(ST_UNKNOWN);
                    else if (cur_command == DEV_ERR_CHECKSUM)
                        end_frame(ST_CHECKSUM);
                    else if (run_sum != got_checksum)
                        end_frame(ST_CHECKSUM);
                    else
                        end_frame(ST_OK);
                end
                default: restart_hunt();
            endcase
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_item(logic kind, logic [31:0] word);
            frp_result_t want;
            if (expected_results.size() == 0) begin
                $error("result item with none expected: tdata 'h%0h, tuser %0d", word, kind);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("kind", int'(want.kind), int'(kind));
            compare_field("data_byte", int'(want.data_byte), int'(word[7:0]));
            compare_field("frame_command", int'(want.frame_command), int'(word[15:8]));
            compare_field("frame_len", int'(want.frame_len), int'(word[23:16]));
            compare_field("status", int'(want.status), int'(word[26:24]));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
    logic [0:0]  s_tuser = 1'b0;    // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [7:0] data_byte, [15:8] frame_command,
                                    // [23:16] frame_len, [26:24] status
    logic [0:0]  m_tuser;           // [0] kind

    frp_scoreboard sb = new();
    bit            gaps_on = 1'b1;
    bit            hold_req = 1'b0;
    logic [7:0]    cur_limit = LENGTH_LIMIT_RST;
    int            items_sent = 0;
    int            cycle_count = 0;

    framed_response_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        gap = gaps_on ? int'($urandom_range(0, 13)) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.predict_item(op, b);
        items_sent++;
    endtask

    task automatic send_frame(input frame_flaw_t flaw, input logic [7:0] cmd,
                              input logic [7:0] len);
        logic [7:0] body[$];
        logic [7:0] sum;
        logic [7:0] b;
        int         cut_at;
        body = {HDR_FIRST, HDR_SECOND, cmd, len};
        sum = cmd + len;
        // An oversized length ends the frame, so nothing follows it.
        if (flaw != FRAME_LONG) begin
            for (int i = 0; i < len; i++) begin
                b = 8'($urandom_range(0, 255));
                body.push_back(b);
                sum = sum + b;
            end
            if (flaw == FRAME_BAD_SUM) begin
                b = 8'($urandom_range(1, 255));
                body.push_back(sum ^ b);
            end else begin
                body.push_back(sum);
            end
            if (flaw == FRAME_BAD_TAIL) begin
                do b = 8'($urandom_range(0, 255)); while (b == TAIL_BYTE);
                body.push_back(b);
            end else begin
                body.push_back(TAIL_BYTE);
            end
        end
        cut_at = (flaw == FRAME_CUT) ? $urandom_range(0, body.size() - 1) : body.size();
        for (int i = 0; i < cut_at; i++)
            send_item(OP_BYTE, body[i]);
        if (flaw == FRAME_CUT)
            send_item(OP_TIMEOUT, 8'($urandom_range(0, 255)));
    endtask

    // Starts from a clean hunt, then either runs the hunt out or completes the
    // header on the last byte it allows and follows it with a timeout.
    task automatic hunt_run(input bit with_header);
        logic [7:0] b;
        send_item(OP_TIMEOUT, 8'($urandom_range(0, 255)));
        for (int i = 0; i < (with_header ? 62 : 64); i++) begin
            do b = 8'($urandom_range(0, 255)); while (b == HDR_FIRST);
            send_item(OP_BYTE, b);
        end
        if (with_header) begin
            send_item(OP_BYTE, HDR_FIRST);
            send_item(OP_BYTE, HDR_SECOND);
            send_item(OP_TIMEOUT, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int quota);
        int          stop_at;
        int          pick;
        logic [7:0]  cmd;
        logic [7:0]  len;
        frame_flaw_t flaw;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 6) == 0)
                cmd = $urandom_range(0, 1) ? DEV_ERR_UNKNOWN : DEV_ERR_CHECKSUM;
            else
                cmd = 8'($urandom_range(0, 255));
            if (cur_limit <= 40 && $urandom_range(0, 9) == 0)
                len = cur_limit;
            else
                len = 8'($urandom_range(0, (cur_limit < 12) ? cur_limit : 12));
            if (pick < 2) begin
                hunt_run(1'b0);
            end else if (pick < 4) begin
                hunt_run(1'b1);
            end else if (pick < 10) begin
                for (int n = $urandom_range(1, 6); n > 0; n--)
                    send_item(($urandom_range(0, 7) == 0) ? OP_TIMEOUT : OP_BYTE,
                              8'($urandom_range(0, 255)));
            end else if (pick < 16 && cur_limit != 8'hFF) begin
                send_frame(FRAME_LONG, cmd, 8'($urandom_range(cur_limit + 1, 255)));
            end else begin
                if (pick < 60)
                    flaw = FRAME_GOOD;
                else if (pick < 72)
                    flaw = FRAME_BAD_SUM;
                else if (pick < 82)
                    flaw = FRAME_BAD_TAIL;
                else
                    flaw = FRAME_CUT;
                send_frame(flaw, cmd, len);
            end
        end
    endtask

    // Waits until every owed result is in and the input register has emptied.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic update_limit(input logic [7:0] value);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_limit(value);
        cur_limit = value;
    endtask

    initial begin : result_side
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = hold_req ? HOLD_CYCLES : (gaps_on ? int'($urandom_range(0, 13)) : 0);
            hold_req = 1'b0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_item(m_tuser[0], m_tdata);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] new_limit;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Short directed run at the reset length limit.
        send_item(OP_TIMEOUT, 8'hFF);
        send_frame(FRAME_GOOD, 8'h00, 8'h00);
        send_frame(FRAME_GOOD, DEV_ERR_UNKNOWN, 8'h00);
        send_frame(FRAME_GOOD, DEV_ERR_CHECKSUM, 8'h01);
        send_frame(FRAME_BAD_SUM, 8'h12, 8'h00);
        send_frame(FRAME_LONG, 8'hFF, 8'hFF);
        run_random(RANDOM_PER_PHASE);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: new_limit = 8'h00;
                1: new_limit = 8'hFF;
                3: new_limit = 8'h01;
                default: new_limit = 8'($urandom_range(2, 254));
            endcase
            update_limit(new_limit);
            if (p == 0)
                hunt_run(1'b0);
            if (p == 1) begin
                // Receiver holds off while long frames stream in back to back.
                gaps_on = 1'b0;
                hold_req = 1'b1;
                send_frame(FRAME_GOOD, 8'($urandom_range(0, 255)), 8'd40);
                send_frame(FRAME_GOOD, 8'($urandom_range(0, 255)), 8'd40);
                send_frame(FRAME_GOOD, 8'($urandom_range(0, 255)), 8'd8);
            end
            if (p == 2)
                hunt_run(1'b1);
            run_random(RANDOM_PER_PHASE);
        end

        settle();
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
